// ----- sv/vfcm_pkg.sv -----
// Shared types, constants and lookup tables for the voxel face-culling mesher.
package vfcm_pkg;

    localparam int CHUNK_SIZE_DEF = 16;
    localparam int VOX_W          = 4;
    localparam int KIND_W         = 2;
    localparam int COORD_W        = 21;
    localparam int COLOR_W        = 32;
    localparam int CHUNK_POS_W    = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int FACE_COUNT     = 6;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    // Block kinds
    localparam logic [KIND_W-1:0] KIND_AIR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLUE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WHITE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_seq_state;

    // One triangle request from the sequencer to the output stage
    typedef struct packed {
        logic [2:0]         face;
        logic               half;
        logic               last;
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COORD_W-1:0] base_z;
    } t_tri_req;

    // Unit-cube corner id -> {dz, dy, dx}
    function automatic logic [2:0] corner_bits(input logic [2:0] id);
        logic [2:0] b;
        unique case (id)
            3'd0: b = 3'b000;
            3'd1: b = 3'b001;
            3'd2: b = 3'b010;
            3'd3: b = 3'b100;
            3'd4: b = 3'b011;
            3'd5: b = 3'b101;
            3'd6: b = 3'b110;
            3'd7: b = 3'b111;
        endcase
        return b;
    endfunction

    // Triangle index (face*2 + half) -> {corner0, corner1, corner2}
    function automatic logic [8:0] tri_corners(input logic [3:0] tri_idx);
        logic [8:0] c;
        unique case (tri_idx)
            4'd0:    c = {3'd0, 3'd3, 3'd6};
            4'd1:    c = {3'd6, 3'd2, 3'd0};
            4'd2:    c = {3'd0, 3'd1, 3'd5};
            4'd3:    c = {3'd5, 3'd3, 3'd0};
            4'd4:    c = {3'd0, 3'd2, 3'd4};
            4'd5:    c = {3'd4, 3'd1, 3'd0};
            4'd6:    c = {3'd7, 3'd5, 3'd1};
            4'd7:    c = {3'd1, 3'd4, 3'd7};
            4'd8:    c = {3'd7, 3'd4, 3'd2};
            4'd9:    c = {3'd2, 3'd6, 3'd7};
            4'd10:   c = {3'd7, 3'd6, 3'd3};
            4'd11:   c = {3'd3, 3'd5, 3'd7};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/vfcm_store.sv -----
// Voxel type memory: one write port, one registered read port.
module vfcm_store #(
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [vfcm_pkg::KIND_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [vfcm_pkg::KIND_W-1:0] o_rdata
);
    import vfcm_pkg::*;

    logic [KIND_W-1:0] r_mem [2**ADDR_W];
    logic [KIND_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/vfcm_seq.sv -----
// Item sequencer: stores writes, walks the center and six neighbors, issues triangles.
module vfcm_seq #(
    parameter int CHUNK_SIZE = vfcm_pkg::CHUNK_SIZE_DEF,
    parameter int ADDR_W     = 3 * $clog2(CHUNK_SIZE)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [vfcm_pkg::VOX_W-1:0]   i_voxel_x,
    input  logic [vfcm_pkg::VOX_W-1:0]   i_voxel_y,
    input  logic [vfcm_pkg::VOX_W-1:0]   i_voxel_z,
    input  logic [vfcm_pkg::KIND_W-1:0]  i_block_kind,
    // vertex offsets from chunk position
    input  logic [vfcm_pkg::COORD_W-1:0] i_off_x,
    input  logic [vfcm_pkg::COORD_W-1:0] i_off_y,
    input  logic [vfcm_pkg::COORD_W-1:0] i_off_z,
    // store access
    output logic                         o_we,
    output logic [ADDR_W-1:0]            o_waddr,
    output logic [vfcm_pkg::KIND_W-1:0]  o_wdata,
    output logic                         o_re,
    output logic [ADDR_W-1:0]            o_raddr,
    input  logic [vfcm_pkg::KIND_W-1:0]  i_rdata,
    // triangle requests
    output logic                         o_req_valid,
    output vfcm_pkg::t_tri_req           o_req,
    input  logic                         i_req_ready
);
    import vfcm_pkg::*;

    localparam int CW = $clog2(CHUNK_SIZE);
    localparam logic [CW-1:0] MAX_C = CW'(CHUNK_SIZE - 1);
    localparam logic [2:0] LAST_STEP = 3'd6;

    t_seq_state r_state, n_state;
    logic [2:0]            r_step, n_step;
    logic [FACE_COUNT-1:0] r_mask, n_mask;
    logic                  r_half, n_half;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [CW-1:0]         r_x, r_y, r_z;
    logic [COORD_W-1:0]    r_base_x, r_base_y, r_base_z;

    logic          acc, in_range;
    logic [CW-1:0] in_x, in_y, in_z;
    logic [2:0]    nxt_step;
    logic          bnd, face_hit;
    logic [2:0]    cur_face;
    logic [FACE_COUNT-1:0] cur_bit, rest;

    assign in_x     = CW'(i_voxel_x);
    assign in_y     = CW'(i_voxel_y);
    assign in_z     = CW'(i_voxel_z);
    assign in_range = (32'(i_voxel_x) < 32'(CHUNK_SIZE)) &&
                      (32'(i_voxel_y) < 32'(CHUNK_SIZE)) &&
                      (32'(i_voxel_z) < 32'(CHUNK_SIZE));
    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && (r_state == S_IDLE);
    assign nxt_step = r_step + 3'd1;

    // Write path straight into the store
    assign o_we    = acc && in_range && (i_op == OP_WRITE);
    assign o_waddr = {in_x, in_y, in_z};
    assign o_wdata = i_block_kind;

    // Read address: center on transfer, then neighbors x-, y-, z-, x+, y+, z+
    always_comb begin
        o_re    = 1'b0;
        o_raddr = {r_x, r_y, r_z};
        if (r_state == S_IDLE) begin
            o_re    = acc && in_range && (i_op == OP_MESH);
            o_raddr = {in_x, in_y, in_z};
        end else if (r_state == S_LOOK) begin
            o_re = (r_step != LAST_STEP);
            unique case (nxt_step)
                3'd1:    o_raddr = {CW'(r_x - 1'b1), r_y, r_z};
                3'd2:    o_raddr = {r_x, CW'(r_y - 1'b1), r_z};
                3'd3:    o_raddr = {r_x, r_y, CW'(r_z - 1'b1)};
                3'd4:    o_raddr = {CW'(r_x + 1'b1), r_y, r_z};
                3'd5:    o_raddr = {r_x, CW'(r_y + 1'b1), r_z};
                3'd6:    o_raddr = {r_x, r_y, CW'(r_z + 1'b1)};
                default: o_raddr = {r_x, r_y, r_z};
            endcase
        end
    end

    // Chunk boundary test for the neighbor whose data is on i_rdata
    always_comb begin
        unique case (r_step)
            3'd1:    bnd = (r_x == '0);
            3'd2:    bnd = (r_y == '0);
            3'd3:    bnd = (r_z == '0);
            3'd4:    bnd = (r_x == MAX_C);
            3'd5:    bnd = (r_y == MAX_C);
            3'd6:    bnd = (r_z == MAX_C);
            default: bnd = 1'b0;
        endcase
    end
    assign face_hit = bnd || (i_rdata == KIND_AIR);

    // Lowest face still pending
    always_comb begin
        cur_face = 3'd0;
        for (int i = FACE_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                cur_face = 3'(i);
            end
        end
    end
    assign cur_bit = FACE_COUNT'(1) << cur_face;
    assign rest    = r_mask & ~cur_bit;

    assign o_req_valid  = (r_state == S_EMIT);
    assign o_req.face   = cur_face;
    assign o_req.half   = r_half;
    assign o_req.last   = r_half && (rest == '0);
    assign o_req.kind   = r_kind;
    assign o_req.base_x = r_base_x;
    assign o_req.base_y = r_base_y;
    assign o_req.base_z = r_base_z;

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_mask  = r_mask;
        n_half  = r_half;
        n_kind  = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (acc && in_range && (i_op == OP_MESH)) begin
                    n_state = S_LOOK;
                    n_step  = 3'd0;
                    n_mask  = '0;
                    n_half  = 1'b0;
                end
            end
            S_LOOK: begin
                n_step = nxt_step;
                if (r_step == 3'd0) begin
                    n_kind = i_rdata;
                    if (i_rdata == KIND_AIR) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_mask[r_step - 3'd1] = face_hit;
                    if (r_step == LAST_STEP) begin
                        n_state = (n_mask == '0) ? S_IDLE : S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_req_ready) begin
                    if (r_half) begin
                        n_half = 1'b0;
                        n_mask = rest;
                        if (rest == '0) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_mask  <= '0;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_mask  <= n_mask;
            r_half  <= n_half;
        end
    end

    // Item payload, captured on transfer
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (acc) begin
            r_x      <= in_x;
            r_y      <= in_y;
            r_z      <= in_z;
            r_base_x <= i_off_x + COORD_W'(i_voxel_x);
            r_base_y <= i_off_y + COORD_W'(i_voxel_y);
            r_base_z <= i_off_z + COORD_W'(i_voxel_z);
        end
    end

endmodule

// ----- sv/vfcm_tri.sv -----
// Triangle output stage: corner lookup, vertex add and the output register.
module vfcm_tri (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  vfcm_pkg::t_tri_req                  i_req,
    output logic                                o_req_ready,
    input  logic [vfcm_pkg::COLOR_W-1:0]        i_color_one,
    input  logic [vfcm_pkg::COLOR_W-1:0]        i_color_two,
    input  logic [vfcm_pkg::COLOR_W-1:0]        i_color_three,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [vfcm_pkg::COLOR_W-1:0]        o_tri_color,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v0_x,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v0_y,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v0_z,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v1_x,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v1_y,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v1_z,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v2_x,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v2_y,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_v2_z,
    output logic                                o_last_tri
);
    import vfcm_pkg::*;

    logic               r_valid;
    logic [COLOR_W-1:0] r_color, n_color;
    logic [COORD_W-1:0] r_v0_x, r_v0_y, r_v0_z;
    logic [COORD_W-1:0] r_v1_x, r_v1_y, r_v1_z;
    logic [COORD_W-1:0] r_v2_x, r_v2_y, r_v2_z;
    logic               r_last;
    logic               load;
    logic [8:0]         corners;
    logic [2:0]         c0, c1, c2;

    assign o_req_ready = !r_valid || !i_stall;
    assign load        = i_req_valid && o_req_ready;

    // Corner offsets for this triangle
    assign corners = tri_corners({i_req.face, i_req.half});
    assign c0      = corner_bits(corners[8:6]);
    assign c1      = corner_bits(corners[5:3]);
    assign c2      = corner_bits(corners[2:0]);

    // Color by block kind
    always_comb begin
        unique case (i_req.kind)
            KIND_RED:  n_color = i_color_one;
            KIND_BLUE: n_color = i_color_two;
            default:   n_color = i_color_three;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_valid <= i_req_valid;
        end
    end

    // Output payload, loaded when the register is free or draining
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_color <= n_color;
            r_v0_x  <= i_req.base_x + COORD_W'(c0[0]);
            r_v0_y  <= i_req.base_y + COORD_W'(c0[1]);
            r_v0_z  <= i_req.base_z + COORD_W'(c0[2]);
            r_v1_x  <= i_req.base_x + COORD_W'(c1[0]);
            r_v1_y  <= i_req.base_y + COORD_W'(c1[1]);
            r_v1_z  <= i_req.base_z + COORD_W'(c1[2]);
            r_v2_x  <= i_req.base_x + COORD_W'(c2[0]);
            r_v2_y  <= i_req.base_y + COORD_W'(c2[1]);
            r_v2_z  <= i_req.base_z + COORD_W'(c2[2]);
            r_last  <= i_req.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_tri_color = r_color;
    assign o_v0_x      = r_v0_x;
    assign o_v0_y      = r_v0_y;
    assign o_v0_z      = r_v0_z;
    assign o_v1_x      = r_v1_x;
    assign o_v1_y      = r_v1_y;
    assign o_v1_z      = r_v1_z;
    assign o_v2_x      = r_v2_x;
    assign o_v2_y      = r_v2_y;
    assign o_v2_z      = r_v2_z;
    assign o_last_tri  = r_last;

endmodule

// ----- sv/voxel_face_cull_mesher.sv -----
// Voxel face-culling mesher top level: config registers, store, sequencer, output stage.
// A write item goes straight into the store and the sequencer stays idle. A mesh item first
// does its store lookups (center plus six neighbors through the single read port) and then
// issues one triangle per cycle, up to 12, while the output side keeps up; none for air.
// Each triangle is registered in the output stage; o_stall holds items off during a mesh item.
// Reset clears control state and colors, sets offsets to -CHUNK_SIZE/2; store stays undefined.
module voxel_face_cull_mesher #(
    parameter int CHUNK_SIZE = vfcm_pkg::CHUNK_SIZE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [vfcm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // item input
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_op,
    input  logic [vfcm_pkg::VOX_W-1:0]             i_voxel_x,
    input  logic [vfcm_pkg::VOX_W-1:0]             i_voxel_y,
    input  logic [vfcm_pkg::VOX_W-1:0]             i_voxel_z,
    input  logic [vfcm_pkg::KIND_W-1:0]            i_block_kind,
    // triangle output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [vfcm_pkg::COLOR_W-1:0]           o_tri_color,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v0_x,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v0_y,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v0_z,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v1_x,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v1_y,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v1_z,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v2_x,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v2_y,
    output logic signed [vfcm_pkg::COORD_W-1:0]    o_v2_z,
    output logic                                   o_last_tri
);
    import vfcm_pkg::*;

    localparam int ADDR_W     = 3 * $clog2(CHUNK_SIZE);
    localparam int HALF_CHUNK = CHUNK_SIZE / 2;
    localparam logic [COORD_W-1:0] OFF_RESET = COORD_W'(-HALF_CHUNK);

    logic [COLOR_W-1:0] r_color_one, r_color_two, r_color_three;
    logic [COORD_W-1:0] r_off_x, r_off_y, r_off_z;
    logic signed [31:0] cp_ext, cp_prod;
    logic [COORD_W-1:0] n_off;

    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [KIND_W-1:0]   wdata, rdata;
    logic                req_valid, req_ready;
    t_tri_req            req;

    // Chunk position -> vertex offset: pos * size - size/2
    assign cp_ext  = 32'(signed'(i_cfg_data[CHUNK_POS_W-1:0]));
    assign cp_prod = cp_ext * 32'(CHUNK_SIZE);
    assign n_off   = COORD_W'(cp_prod - 32'(HALF_CHUNK));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_one   <= '0;
            r_color_two   <= '0;
            r_color_three <= '0;
            r_off_x       <= OFF_RESET;
            r_off_y       <= OFF_RESET;
            r_off_z       <= OFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_ONE:   r_color_one   <= i_cfg_data;
                CFG_COLOR_TWO:   r_color_two   <= i_cfg_data;
                CFG_COLOR_THREE: r_color_three <= i_cfg_data;
                CFG_CHUNK_X:     r_off_x       <= n_off;
                CFG_CHUNK_Y:     r_off_y       <= n_off;
                CFG_CHUNK_Z:     r_off_z       <= n_off;
                default: ;
            endcase
        end
    end

    vfcm_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    vfcm_seq #(
        .CHUNK_SIZE (CHUNK_SIZE),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_voxel_x    (i_voxel_x),
        .i_voxel_y    (i_voxel_y),
        .i_voxel_z    (i_voxel_z),
        .i_block_kind (i_block_kind),
        .i_off_x      (r_off_x),
        .i_off_y      (r_off_y),
        .i_off_z      (r_off_z),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_req_valid  (req_valid),
        .o_req        (req),
        .i_req_ready  (req_ready)
    );

    vfcm_tri u_tri (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_ready   (req_ready),
        .i_color_one   (r_color_one),
        .i_color_two   (r_color_two),
        .i_color_three (r_color_three),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tri_color   (o_tri_color),
        .o_v0_x        (o_v0_x),
        .o_v0_y        (o_v0_y),
        .o_v0_z        (o_v0_z),
        .o_v1_x        (o_v1_x),
        .o_v1_y        (o_v1_y),
        .o_v1_z        (o_v1_z),
        .o_v2_x        (o_v2_x),
        .o_v2_y        (o_v2_y),
        .o_v2_z        (o_v2_z),
        .o_last_tri    (o_last_tri)
    );

endmodule
